/* rtl/core/i2cm_pkg.sv */
// ---------------------------------------------------------------------------
// I2C master bit engine package
// Shared types and constants for the tick-driven I2C master engine.
// ---------------------------------------------------------------------------
package i2cm_pkg;

   // Sizes of the engine state
   localparam int DelayWidth   = 16;
   localparam int StretchWidth = 16;
   localparam int CountWidth   = 8;
   localparam int BitIdxWidth  = 4;
   localparam int ByteWidth    = 8;

   // Register file
   localparam int CsrDataWidth  = 16;
   localparam int CsrIndexWidth = 1;

   // Beat widths on the stream ports
   localparam int ReqDataWidth = 32;
   localparam int RspDataWidth = 16;

   // Register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_PHASE_DELAY   = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_STRETCH_LIMIT = 1'd1;

   // Register reset values
   localparam logic [DelayWidth-1:0]   PHASE_DELAY_RESET   = 16'd5;
   localparam logic [StretchWidth-1:0] STRETCH_LIMIT_RESET = 16'd10000;

   // Bits per byte on the bus
   localparam logic [BitIdxWidth-1:0] BITS_PER_BYTE = 4'd8;

   // Bus phases
   typedef enum logic [4:0] {
      PH_IDLE,
      PH_ST_SDA,
      PH_ST_SCL,
      PH_WB_LOW,
      PH_WB_DATA,
      PH_WB_REL,
      PH_WB_WAIT,
      PH_WA_LOW,
      PH_WA_REL,
      PH_WA_WAIT,
      PH_WA_SAMPLE,
      PH_RB_REL,
      PH_RB_WAIT,
      PH_RB_SAMPLE,
      PH_RA_REL,
      PH_RA_WAIT,
      PH_RA_END,
      PH_SP_REL,
      PH_SP_WAIT,
      PH_SP_SDA_REL,
      PH_SP_DONE
   } phase_type;

   // Engine state held between ticks
   typedef struct packed {
      phase_type                phase;
      logic [DelayWidth-1:0]    delay_count;
      logic [StretchWidth-1:0]  stretch_count;
      logic [BitIdxWidth-1:0]   bit_index;
      logic [ByteWidth-1:0]     shift_reg;
      logic [CountWidth-1:0]    bytes_left;
      logic                     read_mode;
      logic                     scl_low;
      logic                     sda_low;
      logic                     nack_seen;
   } state_type;

   // Register file contents
   typedef struct packed {
      logic [DelayWidth-1:0]   phase_delay;
      logic [StretchWidth-1:0] stretch_limit;
   } cfg_type;

   // One input tick
   typedef struct packed {
      logic                  sda_level;
      logic                  scl_level;
      logic [ByteWidth-1:0]  tx_byte;
      logic [CountWidth-1:0] byte_count;
      logic [6:0]            slave_address;
      logic                  mode;
      logic                  cmd_valid;
   } tick_type;

   // One result beat
   typedef struct packed {
      logic                 success;
      logic                 done_res;
      logic                 rx_valid;
      logic [ByteWidth-1:0] rx_byte;
      logic                 tx_taken;
      logic                 busy_res;
      logic                 sda_drive_low;
      logic                 scl_drive_low;
   } result_type;

endpackage

/* rtl/core/i2cm_step.sv */
// ---------------------------------------------------------------------------
// I2C master tick step
// Next-state and result logic for one tick of the bus engine.
// ---------------------------------------------------------------------------
module i2cm_step (
   input  i2cm_pkg::state_type  cur_state,
   input  i2cm_pkg::cfg_type    cfg,
   input  i2cm_pkg::tick_type   tick,
   output i2cm_pkg::state_type  nxt_state,
   output i2cm_pkg::result_type result
);
   import i2cm_pkg::*;

   logic [StretchWidth-1:0] stretch_inc;
   logic                    stretch_done;
   logic [BitIdxWidth-1:0]  bit_inc;
   logic [ByteWidth-1:0]    rx_shift;
   logic                    taken;
   logic                    rxv;
   logic                    done;
   logic                    ok;

   // Count one stretched sample; finish on SCL high or at the limit
   assign stretch_inc  = cur_state.stretch_count + 1'b1;
   assign stretch_done = tick.scl_level || (stretch_inc >= cfg.stretch_limit);
   assign bit_inc      = cur_state.bit_index + 1'b1;
   assign rx_shift     = {cur_state.shift_reg[ByteWidth-2:0], tick.sda_level};

   // Advance the bus phase
   always_comb begin
      nxt_state = cur_state;
      taken     = 1'b0;
      rxv       = 1'b0;
      done      = 1'b0;
      ok        = 1'b0;

      if (cur_state.delay_count != '0) begin
         nxt_state.delay_count = cur_state.delay_count - 1'b1;
      end else begin
         unique case (cur_state.phase)
            PH_IDLE: begin
               if (tick.cmd_valid) begin
                  nxt_state.read_mode   = tick.mode;
                  nxt_state.bytes_left  = tick.byte_count;
                  nxt_state.nack_seen   = 1'b0;
                  nxt_state.shift_reg   = {tick.slave_address, tick.mode};
                  nxt_state.bit_index   = '0;
                  nxt_state.scl_low     = 1'b0;
                  nxt_state.sda_low     = 1'b0;
                  nxt_state.delay_count = cfg.phase_delay;
                  nxt_state.phase       = PH_ST_SDA;
               end
            end
            PH_ST_SDA: begin
               nxt_state.sda_low     = 1'b1;
               nxt_state.delay_count = cfg.phase_delay;
               nxt_state.phase       = PH_ST_SCL;
            end
            PH_ST_SCL, PH_WB_LOW: begin
               nxt_state.scl_low     = 1'b1;
               nxt_state.delay_count = cfg.phase_delay;
               nxt_state.phase       = (cur_state.phase == PH_ST_SCL) ? PH_WB_LOW : PH_WB_DATA;
            end
            PH_WB_DATA: begin
               nxt_state.sda_low     = ~cur_state.shift_reg[ByteWidth-1];
               nxt_state.delay_count = cfg.phase_delay;
               nxt_state.phase       = PH_WB_REL;
            end
            PH_WB_REL, PH_WA_REL, PH_RB_REL, PH_RA_REL, PH_SP_REL: begin
               // Release SCL and start the stretch watch
               nxt_state.scl_low       = 1'b0;
               nxt_state.stretch_count = '0;
               case (cur_state.phase)
                  PH_WB_REL: nxt_state.phase = PH_WB_WAIT;
                  PH_WA_REL: nxt_state.phase = PH_WA_WAIT;
                  PH_RB_REL: nxt_state.phase = PH_RB_WAIT;
                  PH_RA_REL: nxt_state.phase = PH_RA_WAIT;
                  default:   nxt_state.phase = PH_SP_WAIT;
               endcase
            end
            PH_WB_WAIT: begin
               if (!tick.scl_level) nxt_state.stretch_count = stretch_inc;
               if (stretch_done) begin
                  nxt_state.shift_reg   = {cur_state.shift_reg[ByteWidth-2:0], 1'b0};
                  nxt_state.bit_index   = bit_inc;
                  nxt_state.delay_count = cfg.phase_delay;
                  nxt_state.phase       = (bit_inc >= BITS_PER_BYTE) ? PH_WA_LOW : PH_WB_LOW;
               end
            end
            PH_WA_WAIT, PH_RB_WAIT, PH_RA_WAIT, PH_SP_WAIT: begin
               if (!tick.scl_level) nxt_state.stretch_count = stretch_inc;
               if (stretch_done) begin
                  nxt_state.delay_count = cfg.phase_delay;
                  case (cur_state.phase)
                     PH_WA_WAIT: nxt_state.phase = PH_WA_SAMPLE;
                     PH_RB_WAIT: nxt_state.phase = PH_RB_SAMPLE;
                     PH_RA_WAIT: nxt_state.phase = PH_RA_END;
                     default:    nxt_state.phase = PH_SP_SDA_REL;
                  endcase
               end
            end
            PH_WA_LOW: begin
               nxt_state.scl_low     = 1'b1;
               nxt_state.sda_low     = 1'b0;
               nxt_state.delay_count = cfg.phase_delay;
               nxt_state.phase       = PH_WA_REL;
            end
            PH_WA_SAMPLE: begin
               nxt_state.scl_low     = 1'b1;
               nxt_state.delay_count = cfg.phase_delay;
               if (tick.sda_level || cur_state.bytes_left == '0) begin
                  // NACK or last byte: go to stop
                  if (tick.sda_level) nxt_state.nack_seen = 1'b1;
                  nxt_state.sda_low = 1'b1;
                  nxt_state.phase   = PH_SP_REL;
               end else if (cur_state.read_mode) begin
                  nxt_state.bytes_left = cur_state.bytes_left - 1'b1;
                  nxt_state.shift_reg  = '0;
                  nxt_state.bit_index  = '0;
                  nxt_state.sda_low    = 1'b0;
                  nxt_state.phase      = PH_RB_REL;
               end else begin
                  // Latch the next write byte
                  nxt_state.shift_reg  = tick.tx_byte;
                  taken                = 1'b1;
                  nxt_state.bytes_left = cur_state.bytes_left - 1'b1;
                  nxt_state.bit_index  = '0;
                  nxt_state.phase      = PH_WB_DATA;
               end
            end
            PH_RB_SAMPLE: begin
               nxt_state.shift_reg   = rx_shift;
               nxt_state.bit_index   = bit_inc;
               nxt_state.scl_low     = 1'b1;
               nxt_state.delay_count = cfg.phase_delay;
               if (bit_inc < BITS_PER_BYTE) begin
                  nxt_state.sda_low = 1'b0;
                  nxt_state.phase   = PH_RB_REL;
               end else begin
                  // Byte complete: ACK unless it was the last
                  rxv               = 1'b1;
                  nxt_state.sda_low = (cur_state.bytes_left != '0);
                  nxt_state.phase   = PH_RA_REL;
               end
            end
            PH_RA_END: begin
               nxt_state.scl_low     = 1'b1;
               nxt_state.delay_count = cfg.phase_delay;
               if (cur_state.bytes_left == '0) begin
                  nxt_state.sda_low = 1'b1;
                  nxt_state.phase   = PH_SP_REL;
               end else begin
                  nxt_state.bytes_left = cur_state.bytes_left - 1'b1;
                  nxt_state.shift_reg  = '0;
                  nxt_state.bit_index  = '0;
                  nxt_state.sda_low    = 1'b0;
                  nxt_state.phase      = PH_RB_REL;
               end
            end
            PH_SP_SDA_REL: begin
               nxt_state.sda_low     = 1'b0;
               nxt_state.delay_count = cfg.phase_delay;
               nxt_state.phase       = PH_SP_DONE;
            end
            PH_SP_DONE: begin
               done            = 1'b1;
               ok              = ~cur_state.nack_seen;
               nxt_state.phase = PH_IDLE;
            end
            default: begin
               // Unknown phase code: release the lines and go idle
               nxt_state.scl_low     = 1'b0;
               nxt_state.sda_low     = 1'b0;
               nxt_state.delay_count = '0;
               nxt_state.phase       = PH_IDLE;
            end
         endcase
      end
   end

   // Assemble the result beat from the state after this tick
   always_comb begin
      result.scl_drive_low = nxt_state.scl_low;
      result.sda_drive_low = nxt_state.sda_low;
      result.busy_res      = (nxt_state.phase != PH_IDLE);
      result.tx_taken      = taken;
      result.rx_byte       = rxv ? rx_shift : '0;
      result.rx_valid      = rxv;
      result.done_res      = done;
      result.success       = ok;
   end

endmodule

/* rtl/core/i2c_master_bit_engine.sv */
// ---------------------------------------------------------------------------
// I2C master bit engine
// Tick-driven open-drain I2C master with seven-bit addressing.
// ---------------------------------------------------------------------------
//  Channel  Direction  Beat content
//  req_     in         one 1 us tick: command fields and sampled SCL/SDA
//  rsp_     out        line drives and status after that tick
//  csr_     in         register write (phase_delay, stretch_limit)
//
//  Each tick beat yields exactly one result beat, presented in the cycle after acceptance.
//  A tick is accepted every cycle while the result register is empty or
//  being drained; the bus phase register is updated in the same cycle.
//  A stall on rsp_ holds req_tready low until the result beat is taken.
//  Reset returns the engine to idle with both lines released.
// ---------------------------------------------------------------------------
module i2c_master_bit_engine (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // fields from bit 0: cmd_valid, mode, slave_address[7], byte_count[8],
   // tx_byte[8], scl_level, sda_level, zero fill
   input  logic [i2cm_pkg::ReqDataWidth-1:0]      req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // fields from bit 0: scl_drive_low, sda_drive_low, busy_res, tx_taken,
   // rx_byte[8], rx_valid, done_res, success, zero fill
   output logic [i2cm_pkg::RspDataWidth-1:0]      rsp_tdata,
   input  logic                                   csr_we,
   input  logic [i2cm_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [i2cm_pkg::CsrDataWidth-1:0]      csr_wdata
);
   import i2cm_pkg::*;

   localparam int TickBits   = $bits(tick_type);
   localparam int ResultBits = $bits(result_type);

   state_type  state_ff;
   state_type  state_in;
   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   tick_type   tick;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       req_beat;

   // Accept a tick whenever the result register is free this cycle
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_beat   = req_tvalid & req_tready;
   assign tick       = tick_type'(req_tdata[TickBits-1:0]);

   i2cm_step u_step (
      .cur_state (state_ff),
      .cfg       (cfg_ff),
      .tick      (tick),
      .nxt_state (state_in),
      .result    (result)
   );

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PHASE_DELAY:   cfg_in.phase_delay   = csr_wdata;
            CSR_STRETCH_LIMIT: cfg_in.stretch_limit = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold the result until it is taken, refill on a new tick
   assign rsp_valid_in = req_beat | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase         <= PH_IDLE;
         state_ff.delay_count   <= '0;
         state_ff.stretch_count <= '0;
         state_ff.bit_index     <= '0;
         state_ff.shift_reg     <= '0;
         state_ff.bytes_left    <= '0;
         state_ff.read_mode     <= 1'b0;
         state_ff.scl_low       <= 1'b0;
         state_ff.sda_low       <= 1'b0;
         state_ff.nack_seen     <= 1'b0;
         cfg_ff.phase_delay     <= PHASE_DELAY_RESET;
         cfg_ff.stretch_limit   <= STRETCH_LIMIT_RESET;
         rsp_valid_ff           <= 1'b0;
      end else begin
         if (req_beat) state_ff <= state_in;
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the result beat
   always_ff @(posedge clock) begin
      if (req_beat) rsp_ff <= result;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspDataWidth-ResultBits){1'b0}}, rsp_ff};

endmodule
